// ===== sv/crmc_pkg.sv =====
// Shared constants and types for the cache replacement miss classifier.
package crmc_pkg;

	localparam int CACHE_ENTRIES_DEF = 16;
	localparam int HISTORY_DEPTH_DEF = 256;
	localparam int KEY_BITS_DEF      = 32;

	localparam int CFG_DATA_W = 5;
	localparam int CNT_W      = 32;

	// replacement policy codes
	localparam logic [1:0] POLICY_FIFO  = 2'd0;
	localparam logic [1:0] POLICY_LRU   = 2'd1;
	localparam logic [1:0] POLICY_CLOCK = 2'd2;

	// register indexes
	localparam logic CFG_POLICY   = 1'b0;
	localparam logic CFG_CAPACITY = 1'b1;

	// miss kind codes
	localparam logic [1:0] KIND_HIT        = 2'd0;
	localparam logic [1:0] KIND_COMPULSORY = 2'd1;
	localparam logic [1:0] KIND_CAPACITY   = 2'd2;

	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	typedef struct packed {
		logic [1:0] policy;
		logic [4:0] capacity;
	} cfg_t;

endpackage

// ===== sv/crmc_ram.sv =====
// Generic single write port RAM with registered read.
module crmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/crmc_front.sv =====
// Front end: two-entry request queue that decouples intake from the engine.
module crmc_front #(
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KEY_BITS-1:0] request_key,
	output logic                q_valid,
	input  logic                q_ready,
	output logic [KEY_BITS-1:0] q_key
);

	logic [KEY_BITS-1:0] mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_key    = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= request_key;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== sv/crmc_back.sv =====
// Back end: tag match, victim choice, history scan and directory update.
module crmc_back #(
	parameter int CACHE_ENTRIES = 16,
	parameter int HISTORY_DEPTH = 256,
	parameter int KEY_BITS      = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crmc_pkg::cfg_t      cfg,
	input  logic                q_valid,
	output logic                q_ready,
	input  logic [KEY_BITS-1:0] q_key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit,
	output logic [1:0]          miss_kind,
	output logic                evicted_valid,
	output logic [31:0]         evicted_key,
	output logic                history_full,
	output logic [31:0]         compulsory_total,
	output logic [31:0]         capacity_total
);
	import crmc_pkg::*;

	localparam int N  = CACHE_ENTRIES;
	localparam int SW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);
	localparam int HA = $clog2(HISTORY_DEPTH);
	localparam int HW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(N - 1);
	localparam logic [HW-1:0] HIST_FULL = HW'(HISTORY_DEPTH);
	localparam logic [CW-1:0] N_CW      = CW'(N);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOK   = 3'd1;
	localparam logic [2:0] ST_CLOCK  = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	// directory
	logic [KEY_BITS-1:0] keys_q  [N];
	logic [N-1:0]        valid_q;
	logic [N-1:0]        ref_q;
	logic [SW-1:0]       rank_q  [N];
	logic [CW-1:0]       count_q;
	logic [SW-1:0]       hand_q;
	logic [HW-1:0]       hcount_q;
	logic [CNT_W-1:0]    comp_q, capc_q;

	// per-item work registers
	logic [2:0]          state_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SW-1:0]       slot_q;
	logic                found_q, evict_q, kcap_q, evh_q, pend_q;
	logic [HW-1:0]       scan_q;

	// lookup logic
	logic [N-1:0]  match;
	logic          found;
	logic [SW-1:0] mslot, fslot, oslot;
	logic [CW-1:0] cap_eff;
	logic [KEY_BITS-1:0] evkey;
	logic [KEY_BITS-1:0] rdata;
	logic          hist_we;
	logic          miss_ev;
	logic [KEY_BITS+31:0] evkey_ext;
	logic          commit;
	logic [SW-1:0] r_old;

	assign q_ready = (state_q == ST_IDLE);
	assign evkey   = keys_q[slot_q];
	assign miss_ev = !found_q && evict_q;
	assign commit  = (state_q == ST_COMMIT) && (!out_valid || out_ready);
	assign hist_we = commit && miss_ev && !evh_q && (hcount_q != HIST_FULL);
	assign evkey_ext = {32'b0, evkey};
	assign r_old   = rank_q[slot_q];

	always_comb begin
		found = 1'b0;
		mslot = '0;
		fslot = '0;
		oslot = '0;
		for (int i = N - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (keys_q[i] == key_q);
			if (match[i]) begin
				found = 1'b1;
				mslot = SW'(i);
			end
			if (!valid_q[i]) fslot = SW'(i);
			if (valid_q[i] && rank_q[i] == '0) oslot = SW'(i);
		end
		if (cfg.capacity == 5'd0)      cap_eff = CW'(1);
		else if (int'(cfg.capacity) > N) cap_eff = N_CW;
		else                           cap_eff = CW'(cfg.capacity);
	end

	crmc_ram #(.WIDTH(KEY_BITS), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hcount_q[HA-1:0]),
		.wdata (evkey),
		.raddr (scan_q[HA-1:0]),
		.rdata (rdata)
	);

	// key storage
	always_ff @(posedge clk) begin
		if (commit && !found_q) begin
			keys_q[slot_q] <= key_q;
		end
	end

	// control, directory state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			ref_q     <= '0;
			for (int i = 0; i < N; i++) rank_q[i] <= '0;
			count_q   <= '0;
			hand_q    <= '0;
			hcount_q  <= '0;
			comp_q    <= '0;
			capc_q    <= '0;
			out_valid <= 1'b0;
			found_q   <= 1'b0;
			evict_q   <= 1'b0;
			kcap_q    <= 1'b0;
			evh_q     <= 1'b0;
			pend_q    <= 1'b0;
			scan_q    <= '0;
			slot_q    <= '0;
			key_q     <= '0;
			hit              <= 1'b0;
			miss_kind        <= KIND_HIT;
			evicted_valid    <= 1'b0;
			evicted_key      <= '0;
			history_full     <= 1'b0;
			compulsory_total <= '0;
			capacity_total   <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						key_q   <= q_key;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					found_q <= found;
					kcap_q  <= 1'b0;
					evh_q   <= 1'b0;
					pend_q  <= 1'b0;
					scan_q  <= '0;
					if (found) begin
						slot_q  <= mslot;
						evict_q <= 1'b0;
						state_q <= ST_COMMIT;
					end else if (count_q < cap_eff) begin
						slot_q  <= fslot;
						evict_q <= 1'b0;
						state_q <= ST_SCAN;
					end else if (cfg.policy == POLICY_CLOCK) begin
						evict_q <= 1'b1;
						state_q <= ST_CLOCK;
					end else begin
						slot_q  <= oslot;
						evict_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				// one slot of the clock sweep per cycle
				ST_CLOCK: begin
					hand_q <= (hand_q == LAST_SLOT) ? '0 : hand_q + SW'(1);
					if (valid_q[hand_q] && ref_q[hand_q]) begin
						ref_q[hand_q] <= 1'b0;
					end else if (valid_q[hand_q]) begin
						slot_q  <= hand_q;
						state_q <= ST_SCAN;
					end
				end
				// history scan, one entry per cycle, read data arrives the cycle after its address
				ST_SCAN: begin
					if (scan_q < hcount_q) begin
						scan_q <= scan_q + HW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						if (rdata == key_q) kcap_q <= 1'b1;
						if (rdata == evkey) evh_q  <= 1'b1;
					end
					if (scan_q == hcount_q && !pend_q) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit) begin
						out_valid     <= 1'b1;
						hit           <= found_q;
						evicted_valid <= miss_ev;
						evicted_key   <= miss_ev ? evkey_ext[31:0] : 32'd0;
						history_full  <= miss_ev && !evh_q && (hcount_q == HIST_FULL);
						compulsory_total <= comp_q;
						capacity_total   <= capc_q;
						if (found_q) begin
							miss_kind <= KIND_HIT;
						end else if (kcap_q) begin
							miss_kind <= KIND_CAPACITY;
							if (capc_q != '1) begin
								capc_q         <= capc_q + CNT_W'(1);
								capacity_total <= capc_q + CNT_W'(1);
							end
						end else begin
							miss_kind <= KIND_COMPULSORY;
							if (comp_q != '1) begin
								comp_q           <= comp_q + CNT_W'(1);
								compulsory_total <= comp_q + CNT_W'(1);
							end
						end
						if (hist_we) hcount_q <= hcount_q + HW'(1);
						// rank upkeep
						if (found_q) begin
							if (cfg.policy == POLICY_LRU) begin
								for (int i = 0; i < N; i++) begin
									if (valid_q[i] && SW'(i) != slot_q && rank_q[i] > r_old)
										rank_q[i] <= rank_q[i] - SW'(1);
								end
								rank_q[slot_q] <= SW'(count_q - CW'(1));
							end else if (cfg.policy == POLICY_CLOCK) begin
								ref_q[slot_q] <= 1'b1;
							end
						end else begin
							if (evict_q) begin
								for (int i = 0; i < N; i++) begin
									if (valid_q[i] && SW'(i) != slot_q && rank_q[i] > r_old)
										rank_q[i] <= rank_q[i] - SW'(1);
								end
								rank_q[slot_q] <= SW'(count_q - CW'(1));
							end else begin
								rank_q[slot_q] <= SW'(count_q);
								count_q        <= count_q + CW'(1);
							end
							valid_q[slot_q] <= 1'b1;
							ref_q[slot_q]   <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/cache_replacement_miss_classifier_top.sv =====
// Cache replacement miss classifier: config registers, request queue and engine.
// One item at a time in the engine; a hit skips the history scan.
// A miss scans the eviction history before its result is given.
// CLOCK eviction first sweeps the hand, clearing set reference bits, to a victim.
// A two-item queue takes requests while the engine works; output is registered.
// arst_n clears directory, counters and history fill level; no clearing pass.
module cache_replacement_miss_classifier_top #(
	parameter int CACHE_ENTRIES = crmc_pkg::CACHE_ENTRIES_DEF,
	parameter int HISTORY_DEPTH = crmc_pkg::HISTORY_DEPTH_DEF,
	parameter int KEY_BITS      = crmc_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [crmc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [KEY_BITS-1:0]            request_key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [1:0]                     miss_kind,
	output logic                           evicted_valid,
	output logic [31:0]                    evicted_key,
	output logic                           history_full,
	output logic [31:0]                    compulsory_total,
	output logic [31:0]                    capacity_total
);
	import crmc_pkg::*;

	cfg_t                cfg_q;
	logic                q_valid, q_ready;
	logic [KEY_BITS-1:0] q_key;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy   <= POLICY_FIFO;
			cfg_q.capacity <= CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POLICY:   cfg_q.policy   <= cfg_data[1:0];
				CFG_CAPACITY: cfg_q.capacity <= cfg_data;
				default: ;
			endcase
		end
	end

	crmc_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.request_key (request_key),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_key       (q_key)
	);

	crmc_back #(
		.CACHE_ENTRIES (CACHE_ENTRIES),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.KEY_BITS      (KEY_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (q_valid),
		.q_ready          (q_ready),
		.q_key            (q_key),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hit              (hit),
		.miss_kind        (miss_kind),
		.evicted_valid    (evicted_valid),
		.evicted_key      (evicted_key),
		.history_full     (history_full),
		.compulsory_total (compulsory_total),
		.capacity_total   (capacity_total)
	);

endmodule

// ===== sv/crmc_checker.sv =====
// Port-level checker for the miss classifier, bound to the top level.
module crmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        hit,
	input logic [1:0]  miss_kind,
	input logic        evicted_valid,
	input logic [31:0] evicted_key,
	input logic        history_full
);
	import crmc_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(evicted_key) && $stable(hit))
		else $error("result changed while stalled");

	// a hit carries kind zero and no eviction
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> miss_kind == KIND_HIT && !evicted_valid && !history_full)
		else $error("hit with miss fields");

	// a miss is classified
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> miss_kind == KIND_COMPULSORY || miss_kind == KIND_CAPACITY)
		else $error("miss without kind");

	// history overflow only with an eviction
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && history_full |-> evicted_valid)
		else $error("history full without victim");

endmodule

bind cache_replacement_miss_classifier_top crmc_checker u_crmc_checker (.*);
